// ===== rtl/core/cached_lock_table_revoke_retry_macros.svh =====
// Assertion helpers used by the lock table datapath.
// Both expect signals named clk and rst in the enclosing module.
`ifndef CACHED_LOCK_TABLE_REVOKE_RETRY_MACROS_SVH
`define CACHED_LOCK_TABLE_REVOKE_RETRY_MACROS_SVH

// Same-cycle implication.
`define CLTRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLTRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cltrr_pkg.sv =====
`timescale 1ns / 1ps
package cltrr_pkg;

  localparam int LOCK_W         = 8;
  localparam int CLIENT_W       = 4;
  localparam int MAX_MASK_W     = 16;
  localparam int MAX_MEM_DEPTH  = 256;
  localparam int NUM_LOCKS_DEF  = 256;
  localparam int NUM_CLIENTS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_OK          = 2'd0,
    KIND_RETRY_REPLY = 2'd1,
    KIND_REVOKE      = 2'd2,
    KIND_RETRY_MSG   = 2'd3
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // take request, issue table read
    logic eval;    // table data valid: decide, write back, load plan
    logic emit;    // load next result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic final_now;  // result to be emitted now is the last one
  } sts_t;

endpackage

// ===== rtl/core/cltrr_ram.sv =====
`timescale 1ns / 1ps
module cltrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cltrr_ctrl.sv =====
`timescale 1ns / 1ps
module cltrr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cltrr_pkg::sts_t    sts,
  output cltrr_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEND
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = in_valid && (state == S_IDLE);
  assign cmd.eval   = (state == S_EVAL);
  assign cmd.emit   = (state == S_SEND) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (sts.out_free && sts.final_now) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/cltrr_dp.sv =====
`timescale 1ns / 1ps
`include "cached_lock_table_revoke_retry_macros.svh"
module cltrr_dp #(
  parameter int NUM_LOCKS   = cltrr_pkg::NUM_LOCKS_DEF,
  parameter int NUM_CLIENTS = cltrr_pkg::NUM_CLIENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cltrr_pkg::cmd_t                cmd,
  output cltrr_pkg::sts_t                sts,
  input  logic                           mode,
  input  logic [cltrr_pkg::LOCK_W-1:0]   lock_id,
  input  logic [cltrr_pkg::CLIENT_W-1:0] client_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [cltrr_pkg::CLIENT_W-1:0] dest_client,
  output logic [cltrr_pkg::LOCK_W-1:0]   about_lock,
  output logic                           last
);

  localparam int MEM_DEPTH = (NUM_LOCKS > cltrr_pkg::MAX_MEM_DEPTH) ?
                             cltrr_pkg::MAX_MEM_DEPTH : NUM_LOCKS;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int MASK_W    = (NUM_CLIENTS > cltrr_pkg::MAX_MASK_W) ?
                             cltrr_pkg::MAX_MASK_W : NUM_CLIENTS;
  localparam int CW        = cltrr_pkg::CLIENT_W;
  localparam int ENT_W     = 1 + CW + MASK_W;

  // request
  logic                          req_mode;
  logic [cltrr_pkg::LOCK_W-1:0]  req_lock;
  logic [CW-1:0]                 req_client;

  // table entry valid bits (entry not valid reads as free, no waiters)
  logic [MEM_DEPTH-1:0]          ent_vld;
  logic                          vld_q;
  logic [ENT_W-1:0]              rdata;
  logic [ENT_W-1:0]              wdata;
  logic                          ram_we;
  logic [AW-1:0]                 waddr;

  // plan for the current request
  logic                          rvk_pend;
  logic [CW-1:0]                 rvk_dest;
  logic [MASK_W-1:0]             scan;
  cltrr_pkg::kind_t              fin_kind;

  // output register
  cltrr_pkg::kind_t              out_kind;
  logic [CW-1:0]                 out_dest;
  logic [cltrr_pkg::LOCK_W-1:0]  out_lock;
  logic                          out_last;

  logic                          ent_held;
  logic [CW-1:0]                 ent_owner;
  logic [MASK_W-1:0]             ent_mask;
  logic                          lock_ok;
  logic                          client_ok;
  logic                          in_rng;
  logic                          acq_held;
  logic                          acq_free;
  logic                          rel_own;
  logic [MASK_W-1:0]             client_bit;
  logic [CW-1:0]                 low_idx;

  cltrr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MEM_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.accept),
    .raddr (lock_id[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    ent_held   = vld_q & rdata[ENT_W-1];
    ent_owner  = rdata[ENT_W-2 -: CW];
    ent_mask   = vld_q ? rdata[MASK_W-1:0] : '0;
    lock_ok    = ({9'd0, req_lock} < 17'(NUM_LOCKS));
    client_ok  = ({3'd0, req_client} < 7'(NUM_CLIENTS));
    in_rng     = lock_ok && client_ok;
    acq_held   = in_rng && !req_mode && ent_held;
    acq_free   = in_rng && !req_mode && !ent_held;
    rel_own    = in_rng && req_mode && ent_held && (ent_owner == req_client);
    client_bit = MASK_W'(1) << req_client;
    ram_we     = cmd.eval && (acq_held || acq_free || rel_own);
    waddr      = req_lock[AW-1:0];
    if (acq_free) begin
      wdata = {1'b1, req_client, ent_mask};
    end else if (acq_held) begin
      wdata = {1'b1, ent_owner, ent_mask | client_bit};
    end else begin
      wdata = {1'b0, ent_owner, {MASK_W{1'b0}}};
    end
  end

  // lowest waiting client goes first
  always_comb begin
    low_idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (scan[i]) low_idx = CW'(i);
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.final_now = !rvk_pend && (scan == '0);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode   <= mode;
      req_lock   <= lock_id;
      req_client <= client_id;
      vld_q      <= ent_vld[lock_id[AW-1:0]];
    end
    if (cmd.eval) begin
      rvk_dest <= ent_owner;
      fin_kind <= acq_held ? cltrr_pkg::KIND_RETRY_REPLY : cltrr_pkg::KIND_OK;
    end
    if (cmd.emit) begin
      out_lock <= req_lock;
      if (rvk_pend) begin
        out_kind <= cltrr_pkg::KIND_REVOKE;
        out_dest <= rvk_dest;
        out_last <= 1'b0;
      end else if (scan != '0) begin
        out_kind <= cltrr_pkg::KIND_RETRY_MSG;
        out_dest <= low_idx;
        out_last <= 1'b0;
      end else begin
        out_kind <= fin_kind;
        out_dest <= req_client;
        out_last <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld   <= '0;
      rvk_pend  <= 1'b0;
      scan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        ent_vld[waddr] <= 1'b1;
      end
      if (cmd.eval) begin
        rvk_pend <= acq_held;
        scan     <= rel_own ? ent_mask : '0;
      end else if (cmd.emit) begin
        if (rvk_pend) begin
          rvk_pend <= 1'b0;
        end else begin
          scan <= scan & (scan - MASK_W'(1));
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign kind        = out_kind;
  assign dest_client = out_dest;
  assign about_lock  = out_lock;
  assign last        = out_last;

  `CLTRR_ASSERT_NEXT(a_retry_drops_one, cmd.emit && !rvk_pend && (scan != '0),
    $countones(scan) + 1 == $countones($past(scan)), "retry scan lost more than one waiter")
  `CLTRR_ASSERT_NEXT(a_final_closes, cmd.emit && sts.final_now,
    out_valid && out_last && !rvk_pend && (scan == '0), "final result without closed plan")
  `CLTRR_ASSERT_NOW(a_revoke_not_last, out_valid && (out_kind == cltrr_pkg::KIND_REVOKE),
    !out_last, "revoke message flagged as last")

endmodule

// ===== rtl/core/cached_lock_table_revoke_retry.sv =====
`timescale 1ns / 1ps
// Lock table with revoke / retry messaging.
// Input channel (in_valid/in_ready): one request = mode (0 acquire,
//   1 release), lock_id, client_id.
// Output channel (out_valid/out_ready): one result per handshake = kind,
//   dest_client, about_lock, last. last marks the final result of a request.
// Results per request: 1 (grant, plain OK, out-of-range), 2 (revoke to the
//   owner then RETRY to the requester), or N+1 on owner release (one retry
//   message per waiter, ascending client id, then OK).
// Timing: request accepted in idle with the table read issued at the same
//   edge; decision and write-back in the next cycle, then one result per
//   cycle into the output register while the output is not stalled.
// One request is in flight at a time; the final result may still sit in the
//   output register while the next request is accepted.
// Output stall: results hold in the output register until taken; the
//   emitter waits and in_ready stays low until the final result is loaded.
// Reset: all locks free with empty waiter sets (per-entry valid bits clear
//   at once, no clearing pass); output register empty, in_ready high.
module cached_lock_table_revoke_retry #(
  parameter int NUM_LOCKS   = cltrr_pkg::NUM_LOCKS_DEF,
  parameter int NUM_CLIENTS = cltrr_pkg::NUM_CLIENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [cltrr_pkg::LOCK_W-1:0]   lock_id,
  input  logic [cltrr_pkg::CLIENT_W-1:0] client_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [cltrr_pkg::CLIENT_W-1:0] dest_client,
  output logic [cltrr_pkg::LOCK_W-1:0]   about_lock,
  output logic                           last
);

  cltrr_pkg::cmd_t cmd;  // sequencer commands
  cltrr_pkg::sts_t sts;  // datapath status

  // Sequencer: idle -> evaluate -> send results
  cltrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, request/plan registers, retry scan and output register
  cltrr_dp #(
    .NUM_LOCKS   (NUM_LOCKS),
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .lock_id     (lock_id),
    .client_id   (client_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .dest_client (dest_client),
    .about_lock  (about_lock),
    .last        (last)
  );

endmodule
